// ===== hw/rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit: operation
// codes, controller states, the command and status words between the
// controller and the datapath, and the fixed result widths.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int KIND_W    = 3;
   localparam int NUM_OUT_W = 33;
   localparam int DEN_OUT_W = 31;

   localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
   localparam logic [KIND_W-1:0] KIND_SUB   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MUL   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_DIV   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_SCALE = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_B,
      ST_MUL_C,
      ST_COMBINE,
      ST_TWOS,
      ST_GCD,
      ST_DIV_NUM,
      ST_SAVE_NUM,
      ST_DIV_DEN,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_ERR,
      EMIT_ZERO,
      EMIT_OK
   } emit_type;

   typedef struct packed {
      logic     load;
      logic     mul_a;
      logic     mul_b;
      logic     mul_c;
      logic     combine;
      logic     shift2;
      logic     gcd_load;
      logic     gcd_step;
      logic     div_load_num;
      logic     div_load_den;
      logic     div_step;
      logic     save_num;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic num_zero;
      logic both_even;
      logic a_zero;
      logic div_last;
   } status_type;

endpackage

// ===== hw/rtl/rational_arith_unit_core.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit_core
// Add, subtract, multiply, divide or scale two signed fractions and return
// the result reduced to lowest terms.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_kind and the four operand ports and raise start while busy is
//   low; the word is taken at that clock edge. busy stays high until the
//   unit can take the next word. Each word yields exactly one result word,
//   shown for one cycle with rsp_strobe high; the receiver must take it then.
//   Error cases (zero denominator, divide by zero, unknown kind) return 0/0
//   with rsp_error set; a zero result returns 0/1.
// Each accepted word is first checked; error words strobe straight after
//   the check. Other words run the shared-multiplier products and the
//   combine, after which zero results strobe. The rest drop common factors
//   of two, run the binary GCD loop and divide numerator and denominator
//   by the GCD in two shift-subtract divisions before the strobe; one word
//   is in flight at a time.
// Reset: synchronous, clears the sequencer and the result strobe.
// ----------------------------------------------------------------------------
module rational_arith_unit_core #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [rau_pkg::KIND_W-1:0]            req_kind,
   input  logic signed [OPERAND_WIDTH-1:0]       req_first_num,
   input  logic signed [OPERAND_WIDTH-1:0]       req_first_den,
   input  logic signed [OPERAND_WIDTH-1:0]       req_second_num,
   input  logic signed [OPERAND_WIDTH-1:0]       req_second_den,
   output logic                                  rsp_strobe,
   output logic signed [rau_pkg::NUM_OUT_W-1:0]  rsp_result_num,
   output logic [rau_pkg::DEN_OUT_W-1:0]         rsp_result_den,
   output logic                                  rsp_error
);

   rau_pkg::cmd_type    cmd;
   rau_pkg::status_type status;

   // sequencer: issues one command word per cycle
   rau_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // datapath: operands, shared multiplier, GCD and divider
   rau_datapath #(
      .OPERAND_WIDTH (OPERAND_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_kind       (req_kind),
      .req_first_num  (req_first_num),
      .req_first_den  (req_first_den),
      .req_second_num (req_second_num),
      .req_second_den (req_second_den),
      .cmd            (cmd),
      .status         (status),
      .rsp_strobe     (rsp_strobe),
      .rsp_result_num (rsp_result_num),
      .rsp_result_den (rsp_result_den),
      .rsp_error      (rsp_error)
   );

   // a taken word always starts work in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not start work");

   // a result only follows a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
      else $error("result strobe without a word in flight");

   // one word gives one strobe, never two in a row
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe repeated");

   // the numerator division only loads once the GCD loop is done and the numerator is nonzero
   assert property (@(posedge clock) disable iff (reset)
      cmd.div_load_num |-> (status.a_zero && !status.num_zero))
      else $error("division started before GCD finished");

endmodule

// ===== hw/rtl/rau_controller.sv =====
// ----------------------------------------------------------------------------
// rau_controller
// Sequencer for the rational arithmetic unit: steps the datapath through
// operand checks, products, combine, common-factor removal, GCD and two divisions.
// ----------------------------------------------------------------------------
module rau_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  rau_pkg::status_type status,
   output rau_pkg::cmd_type    cmd
);

   rau_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rau_pkg::ST_IDLE: begin
            if (start) state_in = rau_pkg::ST_CHECK;
         end
         rau_pkg::ST_CHECK: begin
            state_in = status.err ? rau_pkg::ST_IDLE : rau_pkg::ST_MUL_B;
         end
         rau_pkg::ST_MUL_B:   state_in = rau_pkg::ST_MUL_C;
         rau_pkg::ST_MUL_C:   state_in = rau_pkg::ST_COMBINE;
         rau_pkg::ST_COMBINE: state_in = rau_pkg::ST_TWOS;
         rau_pkg::ST_TWOS: begin
            if (status.num_zero) begin
               state_in = rau_pkg::ST_IDLE;
            end else if (!status.both_even) begin
               state_in = rau_pkg::ST_GCD;
            end
         end
         rau_pkg::ST_GCD: begin
            if (status.a_zero) state_in = rau_pkg::ST_DIV_NUM;
         end
         rau_pkg::ST_DIV_NUM: begin
            if (status.div_last) state_in = rau_pkg::ST_SAVE_NUM;
         end
         rau_pkg::ST_SAVE_NUM: state_in = rau_pkg::ST_DIV_DEN;
         rau_pkg::ST_DIV_DEN: begin
            if (status.div_last) state_in = rau_pkg::ST_FINISH;
         end
         rau_pkg::ST_FINISH: state_in = rau_pkg::ST_IDLE;
         default:             state_in = rau_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         rau_pkg::ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         rau_pkg::ST_CHECK: begin
            if (status.err) begin
               cmd.emit = rau_pkg::EMIT_ERR;
            end else begin
               cmd.mul_a = 1'b1;
            end
         end
         rau_pkg::ST_MUL_B:   cmd.mul_b   = 1'b1;
         rau_pkg::ST_MUL_C:   cmd.mul_c   = 1'b1;
         rau_pkg::ST_COMBINE: cmd.combine = 1'b1;
         rau_pkg::ST_TWOS: begin
            if (status.num_zero) begin
               cmd.emit = rau_pkg::EMIT_ZERO;
            end else if (status.both_even) begin
               cmd.shift2 = 1'b1;
            end else begin
               cmd.gcd_load = 1'b1;
            end
         end
         rau_pkg::ST_GCD: begin
            if (status.a_zero) begin
               cmd.div_load_num = 1'b1;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         rau_pkg::ST_DIV_NUM: cmd.div_step = 1'b1;
         rau_pkg::ST_SAVE_NUM: begin
            cmd.save_num     = 1'b1;
            cmd.div_load_den = 1'b1;
         end
         rau_pkg::ST_DIV_DEN: cmd.div_step = 1'b1;
         rau_pkg::ST_FINISH:  cmd.emit     = rau_pkg::EMIT_OK;
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

// ===== hw/rtl/rau_datapath.sv =====
// ----------------------------------------------------------------------------
// rau_datapath
// Operand registers, one shared multiplier, add/subtract combine, binary GCD
// and a shift-subtract divider, plus the registered result word.
// ----------------------------------------------------------------------------
module rau_datapath #(
   parameter int OPERAND_WIDTH = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [rau_pkg::KIND_W-1:0]            req_kind,
   input  logic signed [OPERAND_WIDTH-1:0]       req_first_num,
   input  logic signed [OPERAND_WIDTH-1:0]       req_first_den,
   input  logic signed [OPERAND_WIDTH-1:0]       req_second_num,
   input  logic signed [OPERAND_WIDTH-1:0]       req_second_den,
   input  rau_pkg::cmd_type                      cmd,
   output rau_pkg::status_type                   status,
   output logic                                  rsp_strobe,
   output logic signed [rau_pkg::NUM_OUT_W-1:0]  rsp_result_num,
   output logic [rau_pkg::DEN_OUT_W-1:0]         rsp_result_den,
   output logic                                  rsp_error
);

   localparam int W  = OPERAND_WIDTH;
   localparam int NW = 2 * W;
   localparam int CW = $clog2(NW);
   localparam int XN = (NW + 1 > rau_pkg::NUM_OUT_W) ? NW + 1 : rau_pkg::NUM_OUT_W;
   localparam int XD = (NW > rau_pkg::DEN_OUT_W) ? NW : rau_pkg::DEN_OUT_W;

   // operand magnitudes and signs
   logic [rau_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [W-1:0] mn1_ff, mn1_in, md1_ff, md1_in, mn2_ff, mn2_in, md2_ff, md2_in;
   logic         s1_ff, s1_in, s2_ff, s2_in, sn2_ff, sn2_in, err_ff, err_in;

   // working values
   logic [NW-1:0] num_ff, num_in, den_ff, den_in, t2_ff, t2_in;
   logic          neg_ff, neg_in;
   logic [NW-1:0] a_ff, a_in, b_ff, b_in, dq_ff, dq_in, rem_ff, rem_in;
   logic [CW-1:0] cnt_ff, cnt_in;

   // result word
   logic                                 strobe_ff, strobe_in;
   logic signed [rau_pkg::NUM_OUT_W-1:0] rnum_ff, rnum_in;
   logic [rau_pkg::DEN_OUT_W-1:0]        rden_ff, rden_in;
   logic                                 rerr_ff, rerr_in;

   logic [W-1:0]  mag_n1, mag_d1, mag_n2, mag_d2;
   logic [W-1:0]  mul_l, mul_r;
   logic [NW-1:0] prod;

   assign mag_n1 = req_first_num[W-1]  ? W'(-req_first_num)  : W'(req_first_num);
   assign mag_d1 = req_first_den[W-1]  ? W'(-req_first_den)  : W'(req_first_den);
   assign mag_n2 = req_second_num[W-1] ? W'(-req_second_num) : W'(req_second_num);
   assign mag_d2 = req_second_den[W-1] ? W'(-req_second_den) : W'(req_second_den);

   // shared multiplier operand select
   always_comb begin
      mul_l = cmd.mul_a ? mn1_ff : md1_ff;
      if (cmd.mul_a) begin
         mul_r = (kind_ff inside {rau_pkg::KIND_MUL, rau_pkg::KIND_SCALE}) ? mn2_ff : md2_ff;
      end else if (cmd.mul_b) begin
         if (kind_ff == rau_pkg::KIND_DIV) begin
            mul_r = mn2_ff;
         end else if (kind_ff == rau_pkg::KIND_SCALE) begin
            mul_r = W'(1);
         end else begin
            mul_r = md2_ff;
         end
      end else begin
         mul_r = mn2_ff;
      end
   end

   assign prod = NW'(mul_l) * NW'(mul_r);

   always_comb begin
      logic          st2;
      logic [NW:0]   shifted;
      logic [NW:0]   trial;
      logic          ge;
      logic signed [NW:0] qn;
      logic signed [XN-1:0] qn_ext;
      logic [XD-1:0] qd_ext;

      kind_in = kind_ff;
      mn1_in  = mn1_ff;
      md1_in  = md1_ff;
      mn2_in  = mn2_ff;
      md2_in  = md2_ff;
      s1_in   = s1_ff;
      s2_in   = s2_ff;
      sn2_in  = sn2_ff;
      err_in  = err_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      t2_in   = t2_ff;
      neg_in  = neg_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      dq_in   = dq_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      rnum_in = rnum_ff;
      rden_in = rden_ff;
      rerr_in = rerr_ff;
      st2     = 1'b0;
      shifted = {rem_ff, dq_ff[NW-1]};
      trial   = shifted - {1'b0, b_ff};
      ge      = shifted >= {1'b0, b_ff};
      qn      = neg_ff ? -signed'({1'b0, num_ff}) : signed'({1'b0, num_ff});
      qn_ext  = XN'(qn);
      qd_ext  = XD'(dq_ff);

      if (cmd.load) begin
         kind_in = req_kind;
         mn1_in  = mag_n1;
         md1_in  = mag_d1;
         mn2_in  = mag_n2;
         md2_in  = mag_d2;
         s1_in   = req_first_num[W-1] ^ req_first_den[W-1];
         s2_in   = req_second_num[W-1] ^ req_second_den[W-1];
         sn2_in  = req_second_num[W-1];
         err_in  = (req_kind > rau_pkg::KIND_SCALE) || (mag_d1 == '0)
                 || ((req_kind != rau_pkg::KIND_SCALE) && (mag_d2 == '0))
                 || ((req_kind == rau_pkg::KIND_DIV) && (mag_n2 == '0));
      end

      if (cmd.mul_a) num_in = prod;
      if (cmd.mul_b) den_in = prod;
      if (cmd.mul_c) t2_in  = prod;

      // fold the second term in with its sign; products only set the sign
      if (cmd.combine) begin
         if (kind_ff inside {rau_pkg::KIND_ADD, rau_pkg::KIND_SUB}) begin
            st2 = (kind_ff == rau_pkg::KIND_SUB) ? ~s2_ff : s2_ff;
            if (s1_ff == st2) begin
               num_in = num_ff + t2_ff;
               neg_in = s1_ff;
            end else if (num_ff >= t2_ff) begin
               num_in = num_ff - t2_ff;
               neg_in = s1_ff;
            end else begin
               num_in = t2_ff - num_ff;
               neg_in = st2;
            end
         end else begin
            neg_in = s1_ff ^ ((kind_ff == rau_pkg::KIND_SCALE) ? sn2_ff : s2_ff);
         end
      end

      // drop common factors of two from both terms
      if (cmd.shift2) begin
         num_in = num_ff >> 1;
         den_in = den_ff >> 1;
      end

      if (cmd.gcd_load) begin
         a_in = num_ff;
         b_in = den_ff;
      end

      // binary GCD step with at least one odd operand; b ends as the GCD
      if (cmd.gcd_step) begin
         if (!a_ff[0]) begin
            a_in = a_ff >> 1;
         end else if (!b_ff[0]) begin
            b_in = b_ff >> 1;
         end else if (a_ff >= b_ff) begin
            a_in = (a_ff - b_ff) >> 1;
         end else begin
            b_in = (b_ff - a_ff) >> 1;
         end
      end

      if (cmd.div_load_num) begin
         dq_in  = num_ff;
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.div_load_den) begin
         dq_in  = den_ff;
         rem_in = '0;
         cnt_in = '0;
      end
      if (cmd.save_num) num_in = dq_ff;

      // restoring divide by the GCD, one quotient bit per step
      if (cmd.div_step) begin
         rem_in = ge ? trial[NW-1:0] : shifted[NW-1:0];
         dq_in  = {dq_ff[NW-2:0], ge};
         cnt_in = cnt_ff + CW'(1);
      end

      strobe_in = (cmd.emit != rau_pkg::EMIT_NONE);
      case (cmd.emit)
         rau_pkg::EMIT_ERR: begin
            rnum_in = '0;
            rden_in = '0;
            rerr_in = 1'b1;
         end
         rau_pkg::EMIT_ZERO: begin
            rnum_in = '0;
            rden_in = rau_pkg::DEN_OUT_W'(1);
            rerr_in = 1'b0;
         end
         rau_pkg::EMIT_OK: begin
            rnum_in = qn_ext[rau_pkg::NUM_OUT_W-1:0];
            rden_in = qd_ext[rau_pkg::DEN_OUT_W-1:0];
            rerr_in = 1'b0;
         end
         default: begin
            rnum_in = rnum_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      mn1_ff  <= mn1_in;
      md1_ff  <= md1_in;
      mn2_ff  <= mn2_in;
      md2_ff  <= md2_in;
      s1_ff   <= s1_in;
      s2_ff   <= s2_in;
      sn2_ff  <= sn2_in;
      err_ff  <= err_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      t2_ff   <= t2_in;
      neg_ff  <= neg_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      dq_ff   <= dq_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      rnum_ff <= rnum_in;
      rden_ff <= rden_in;
      rerr_ff <= rerr_in;
   end

   assign status.err       = err_ff;
   assign status.num_zero  = (num_ff == '0);
   assign status.both_even = !num_ff[0] && !den_ff[0];
   assign status.a_zero    = (a_ff == '0);
   assign status.div_last  = (cnt_ff == CW'(NW - 1));

   assign rsp_strobe     = strobe_ff;
   assign rsp_result_num = rnum_ff;
   assign rsp_result_den = rden_ff;
   assign rsp_error      = rerr_ff;

endmodule

// ===== tb/sv/rational_arith_unit_core_tb.sv =====
// ----------------------------------------------------------------------------
// rational_arith_unit_core_tb
// Self-checking bench for the rational arithmetic unit. Drives operation
// words through the start/busy handshake with random idle gaps, predicts
// each reduced fraction in the bench, and compares every strobed result
// word field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module rational_arith_unit_core_tb;

   localparam int OPW = 16;

   // Kinds past scale have no package name; the unit flags all of them.
   localparam logic [rau_pkg::KIND_W-1:0] KIND_RSVD5 = 3'd5;
   localparam logic [rau_pkg::KIND_W-1:0] KIND_RSVD6 = 3'd6;
   localparam logic [rau_pkg::KIND_W-1:0] KIND_RSVD7 = 3'd7;

   localparam logic signed [OPW-1:0] OP_MIN = {1'b1, {(OPW-1){1'b0}}};
   localparam logic signed [OPW-1:0] OP_MAX = {1'b0, {(OPW-1){1'b1}}};

   localparam int RANDOM_WORDS = 850;
   // Allowance for one worst-case word: the two divisions, the factor-of-two
   // shifts, the GCD steps and fixed overhead, all growing with 2*OPW.
   localparam int DRAIN_CYCLES = 5 * (2 * OPW) + 40;

   typedef struct packed {
      logic signed [rau_pkg::NUM_OUT_W-1:0] num;
      logic [rau_pkg::DEN_OUT_W-1:0]        den;
      logic                                 err;
   } fraction_word_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  start = 1'b0;
   logic                                  busy;
   logic [rau_pkg::KIND_W-1:0]            req_kind = '0;
   logic signed [OPW-1:0]                 req_first_num = '0;
   logic signed [OPW-1:0]                 req_first_den = '0;
   logic signed [OPW-1:0]                 req_second_num = '0;
   logic signed [OPW-1:0]                 req_second_den = '0;
   logic                                  rsp_strobe;
   logic signed [rau_pkg::NUM_OUT_W-1:0]  rsp_result_num;
   logic [rau_pkg::DEN_OUT_W-1:0]         rsp_result_den;
   logic                                  rsp_error;

   fraction_word_type pending_fractions[$];
   int unsigned       mismatch_count = 0;
   bit                idle_gaps_on = 1'b1;

   rational_arith_unit_core #(
      .OPERAND_WIDTH(OPW)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_kind       (req_kind),
      .req_first_num  (req_first_num),
      .req_first_den  (req_first_den),
      .req_second_num (req_second_num),
      .req_second_den (req_second_den),
      .rsp_strobe     (rsp_strobe),
      .rsp_result_num (rsp_result_num),
      .rsp_result_den (rsp_result_den),
      .rsp_error      (rsp_error)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Hard stop in case the unit hangs or drops a word.
   initial begin
      #20000000;
      $display("rational_arith_unit_core_tb NOT OK");
      $finish;
   end

   // Magnitude of a two's complement operand; the most negative value maps
   // to 2^(OPW-1), so the result is taken as unsigned.
   function automatic logic [63:0] operand_magnitude(input logic signed [OPW-1:0] v);
      logic [OPW-1:0] t;
      t = v[OPW-1] ? (~v + 1'b1) : v;
      return {{(64-OPW){1'b0}}, t};
   endfunction

   function automatic logic [63:0] magnitude_gcd(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   // Predict the reduced fraction for one word. All arithmetic is kept in
   // sign-magnitude form, matching the unit, so nothing overflows 64 bits.
   function automatic fraction_word_type predict_reduced_fraction(
      input logic [rau_pkg::KIND_W-1:0] kind,
      input logic signed [OPW-1:0]      fn,
      input logic signed [OPW-1:0]      fd,
      input logic signed [OPW-1:0]      sn,
      input logic signed [OPW-1:0]      sd
   );
      fraction_word_type w;
      logic [63:0]       mn1, md1, mn2, md2, t1, t2, num, den, g, signed_num;
      logic              s1, s2, st2, neg, bad;
      mn1 = operand_magnitude(fn);
      md1 = operand_magnitude(fd);
      mn2 = operand_magnitude(sn);
      md2 = operand_magnitude(sd);
      s1  = fn[OPW-1] ^ fd[OPW-1];
      s2  = sn[OPW-1] ^ sd[OPW-1];
      neg = 1'b0;
      num = '0;
      den = 64'd1;
      bad = (kind > rau_pkg::KIND_SCALE) || (md1 == 0)
         || (kind != rau_pkg::KIND_SCALE && md2 == 0)
         || (kind == rau_pkg::KIND_DIV && mn2 == 0);
      if (bad) begin
         w.num = '0;
         w.den = '0;
         w.err = 1'b1;
         return w;
      end
      case (kind)
         rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: begin
            t1  = mn1 * md2;
            t2  = mn2 * md1;
            st2 = (kind == rau_pkg::KIND_SUB) ? ~s2 : s2;
            den = md1 * md2;
            if (s1 == st2) begin
               num = t1 + t2;
               neg = s1;
            end else if (t1 >= t2) begin
               num = t1 - t2;
               neg = s1;
            end else begin
               num = t2 - t1;
               neg = st2;
            end
         end
         rau_pkg::KIND_MUL: begin
            num = mn1 * mn2;
            den = md1 * md2;
            neg = s1 ^ s2;
         end
         rau_pkg::KIND_DIV: begin
            num = mn1 * md2;
            den = md1 * mn2;
            neg = s1 ^ s2;
         end
         default: begin
            num = mn1 * mn2;
            den = md1;
            neg = s1 ^ sn[OPW-1];
         end
      endcase
      w.err = 1'b0;
      if (num == 0) begin
         w.num = '0;
         w.den = 1;
         return w;
      end
      g   = magnitude_gcd(num, den);
      num = num / g;
      den = den / g;
      signed_num = neg ? (~num + 1) : num;
      w.num = signed_num[rau_pkg::NUM_OUT_W-1:0];
      w.den = den[rau_pkg::DEN_OUT_W-1:0];
      return w;
   endfunction

   // Send one word: idle a random number of cycles, raise start with the
   // operands, hold until the unit takes it, then queue the prediction.
   // start is left high after the accept so a back-to-back word needs no
   // second assignment in the same step.
   task automatic send_word(
      input logic [rau_pkg::KIND_W-1:0] kind,
      input logic signed [OPW-1:0]      fn,
      input logic signed [OPW-1:0]      fd,
      input logic signed [OPW-1:0]      sn,
      input logic signed [OPW-1:0]      sd
   );
      int gap;
      gap = idle_gaps_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_kind       <= kind;
      req_first_num  <= fn;
      req_first_den  <= fd;
      req_second_num <= sn;
      req_second_den <= sd;
      do begin
         @(posedge clock);
      end while (busy);
      pending_fractions.push_back(predict_reduced_fraction(kind, fn, fd, sn, sd));
   endtask

   // Check each strobed result word against the oldest prediction.
   always @(posedge clock) begin
      fraction_word_type exp_w;
      if (!reset && rsp_strobe) begin
         if (pending_fractions.size() == 0) begin
            $display("%0t: result word with nothing expected: num %0d den %0d err %0b",
                     $time, rsp_result_num, rsp_result_den, rsp_error);
            mismatch_count++;
         end else begin
            exp_w = pending_fractions.pop_front();
            if (rsp_result_num !== exp_w.num) begin
               $display("%0t: result_num expected %0d actual %0d",
                        $time, exp_w.num, rsp_result_num);
               mismatch_count++;
            end
            if (rsp_result_den !== exp_w.den) begin
               $display("%0t: result_den expected %0d actual %0d",
                        $time, exp_w.den, rsp_result_den);
               mismatch_count++;
            end
            if (rsp_error !== exp_w.err) begin
               $display("%0t: error expected %0b actual %0b",
                        $time, exp_w.err, rsp_error);
               mismatch_count++;
            end
         end
      end
   end

   // Operand mix: full range for bit coverage, small values so that GCD
   // reduction does real work, and the signed extremes.
   function automatic logic signed [OPW-1:0] pick_operand();
      int v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5, 6:    v = int'($urandom_range(0, 40)) - 20;
         7: begin
            case ($urandom_range(0, 4))
               0:       v = OP_MIN;
               1:       v = OP_MAX;
               2:       v = -1;
               3:       v = 1;
               default: v = 0;
            endcase
         end
         default:    v = (int'($urandom_range(0, 510)) - 255) <<< $urandom_range(0, 7);
      endcase
      return v[OPW-1:0];
   endfunction

   function automatic logic signed [OPW-1:0] pick_nonzero_operand();
      logic signed [OPW-1:0] v;
      do begin
         v = pick_operand();
      end while (v == 0);
      return v;
   endfunction

   task automatic test_each_kind();
      send_word(rau_pkg::KIND_ADD,   16'sd1,  16'sd2,   16'sd1,  16'sd3);
      send_word(rau_pkg::KIND_SUB,   16'sd1,  16'sd2,   16'sd1,  16'sd3);
      send_word(rau_pkg::KIND_MUL,  -16'sd3,  16'sd4,   16'sd2, -16'sd9);
      send_word(rau_pkg::KIND_DIV,   16'sd3,  16'sd4,  -16'sd9,  16'sd2);
      send_word(rau_pkg::KIND_SCALE, 16'sd5, -16'sd10,  16'sd4,  16'sd7);
   endtask

   task automatic test_error_cases();
      // zero first denominator, zero second denominator, and scale where a
      // zero second denominator must be ignored
      send_word(rau_pkg::KIND_ADD,   16'sd1, 16'sd0,  16'sd1, 16'sd3);
      send_word(rau_pkg::KIND_MUL,   16'sd1, 16'sd2,  16'sd1, 16'sd0);
      send_word(rau_pkg::KIND_SCALE, 16'sd3, 16'sd9,  16'sd6, 16'sd0);
      // divide by a zero fraction
      send_word(rau_pkg::KIND_DIV,   16'sd1, 16'sd2,  16'sd0, 16'sd5);
      // unknown kinds
      send_word(KIND_RSVD5, 16'sd1, 16'sd2,  16'sd1, 16'sd3);
      send_word(KIND_RSVD6, 16'sd1, 16'sd2,  16'sd1, 16'sd3);
      send_word(KIND_RSVD7, 16'sd1, 16'sd2,  16'sd1, 16'sd3);
   endtask

   task automatic test_zero_results();
      send_word(rau_pkg::KIND_ADD,   16'sd1,  16'sd2, -16'sd1, 16'sd2);
      send_word(rau_pkg::KIND_MUL,   16'sd0,  16'sd5,  16'sd3, 16'sd4);
      send_word(rau_pkg::KIND_SCALE, 16'sd7,  16'sd3,  16'sd0, 16'sd1);
      send_word(rau_pkg::KIND_DIV,   16'sd0, -16'sd3,  16'sd2, 16'sd5);
   endtask

   task automatic test_extremes();
      send_word(rau_pkg::KIND_ADD,   OP_MIN, OP_MIN, OP_MIN, OP_MIN);
      send_word(rau_pkg::KIND_MUL,   OP_MAX, OP_MIN, OP_MIN, OP_MAX);
      send_word(rau_pkg::KIND_SUB,   OP_MIN, 16'sd1, OP_MAX, 16'sd1);
      send_word(rau_pkg::KIND_DIV,   OP_MIN, OP_MAX, OP_MAX, OP_MIN);
      send_word(rau_pkg::KIND_SCALE, OP_MIN, 16'sd1, OP_MIN, OP_MAX);
      send_word(rau_pkg::KIND_ADD,   OP_MAX, OP_MIN, OP_MIN, OP_MAX);
      send_word(rau_pkg::KIND_SUB,   OP_MIN, OP_MAX, OP_MAX, OP_MIN);
   endtask

   // Mostly well-formed words with random operands; the rest is noise that
   // can hit zero denominators, divide by zero and unknown kinds.
   task automatic test_random_words();
      logic [rau_pkg::KIND_W-1:0] kind;
      logic signed [OPW-1:0]      fn, fd, sn, sd;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         // toggle stretches of back-to-back traffic
         if (i % 40 == 0) idle_gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 9) != 0) begin
            kind = rau_pkg::KIND_W'($urandom_range(rau_pkg::KIND_ADD, rau_pkg::KIND_SCALE));
            fn   = pick_operand();
            fd   = pick_nonzero_operand();
            sn   = (kind == rau_pkg::KIND_DIV) ? pick_nonzero_operand() : pick_operand();
            sd   = (kind == rau_pkg::KIND_SCALE) ? pick_operand() : pick_nonzero_operand();
         end else begin
            kind = rau_pkg::KIND_W'($urandom_range(0, 7));
            fn   = pick_operand();
            fd   = pick_operand();
            sn   = pick_operand();
            sd   = pick_operand();
         end
         send_word(kind, fn, fd, sn, sd);
      end
      idle_gaps_on = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_each_kind();
      test_error_cases();
      test_zero_results();
      test_extremes();
      test_random_words();

      // drop start, drain the unit, then allow for a stray late word
      start <= 1'b0;
      while (pending_fractions.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_fractions.size() == 0) begin
         $display("rational_arith_unit_core_tb OK");
      end else begin
         $display("rational_arith_unit_core_tb NOT OK");
      end
      $finish;
   end

endmodule
